// ----- hdl/aat_pkg.sv -----
// Package for the bounding-box transform: sizes, field offsets, types and codes.
`timescale 1ns / 1ps

package aat_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int COEF_COUNT  = 12;
  localparam int COEF_IDX_W  = 4;
  localparam int AXES        = 3;
  localparam int AXIS_W      = 2;
  localparam int COL_W       = 2;
  localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
  // three products plus the shifted translation need two guard bits
  localparam int ACC_WIDTH   = PROD_WIDTH + 2;

  // input word: coef_index, coef_value, box_min_x/y/z, box_max_x/y/z
  localparam int COEF_LSB    = COEF_IDX_W;
  localparam int BOX_LSB     = COEF_IDX_W + COORD_WIDTH;
  localparam int IN_DATA_W   = ((COEF_IDX_W + 7 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((6 * COORD_WIDTH + 7) / 8) * 8;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [ACC_WIDTH-1:0]   acc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_BOX  = 1'b1
  } opcode_e;

  // column code that reads the translation entry of a row
  localparam logic [COL_W-1:0] COL_TRANS = 2'd3;
  localparam logic [COL_W-1:0] COL_LAST  = 2'd2;

  // travels with each product from the multiplier to the accumulators
  typedef struct packed {
    logic              valid;
    logic              side;   // 0: product with the min bound, 1: with the max bound
    logic              first;  // first column of the row
    logic              last;   // closing product of the row
    logic [AXIS_W-1:0] axis;
  } tag_t;

  typedef struct packed {
    coord_t value;
    logic   sat;
  } fin_t;

endpackage

// ----- hdl/aabb_affine_transform_top.sv -----
// Bounding-box transform under an affine map, one shared multiplier and a sequencer.
`timescale 1ns / 1ps

// Load word (tuser = 0): coefficient written at the accept edge.
// Box word (tuser = 1): per row, a translation fetch, then six coefficient-by-bound
//   products on the multiplier; the result word is raised once all three rows are done.
// No new word is accepted until the result word is taken; the single multiplier is shared.
// rst_ni is asynchronous, active low: clears the twelve coefficients, the sequencer and
//   the output valid.
module aabb_affine_transform_top import aat_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // coef_index[3:0], coef_value, box_min_x, box_min_y, box_min_z,
  // box_max_x, box_max_y, box_max_z, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tuser_i,   // opcode
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tuser_o    // saturated
);

  state_e state_q, state_d;

  // matrix rows 0..2, four columns each, row-major
  coord_t coef_q [COEF_COUNT];

  // box bounds held for the run
  coord_t lo_bnd_q [AXES];
  coord_t hi_bnd_q [AXES];

  // sequencer
  logic              issue_q;
  logic [AXIS_W-1:0] axis_q;
  logic [COL_W-1:0]  col_q;
  logic              side_q;

  // multiplier stage
  coord_t coef_sel;
  coord_t bnd_sel;
  prod_t  prod_q;
  tag_t   tag_q;

  // accumulate stage
  coord_t seed_q;
  prod_t  p_q;
  acc_t   lo_acc_q, hi_acc_q;
  acc_t   seed_ext, lo_base, hi_base;
  prod_t  mn, mx;
  logic              fin_q;
  logic [AXIS_W-1:0] fin_axis_q;

  // result word
  coord_t out_lo_q [AXES];
  coord_t out_hi_q [AXES];
  logic   sat_q;
  fin_t   fin_lo, fin_hi;

  logic in_fire, out_fire, load_fire, box_fire;
  logic [COEF_IDX_W-1:0] in_idx;
  coord_t in_coef;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire  = m_axis_tvalid_o && m_axis_tready_i;
  assign load_fire = in_fire && (s_axis_tuser_i == OP_LOAD);
  assign box_fire  = in_fire && (s_axis_tuser_i == OP_BOX);
  assign in_idx    = s_axis_tdata_i[COEF_LSB-1:0];
  assign in_coef   = s_axis_tdata_i[COEF_LSB +: COORD_WIDTH];

  // round to nearest (ties up), drop the fraction, clamp to the coordinate range
  function automatic fin_t finish(acc_t s);
    acc_t rnd;
    acc_t sh;
    acc_t top;
    acc_t bot;
    fin_t r;
    rnd = s + (acc_t'(1) <<< (FRAC_BITS - 1));
    sh  = rnd >>> FRAC_BITS;
    top = acc_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    bot = -top - acc_t'(1);
    r.sat   = 1'b0;
    r.value = sh[COORD_WIDTH-1:0];
    if (sh > top) begin
      r.sat   = 1'b1;
      r.value = top[COORD_WIDTH-1:0];
    end else if (sh < bot) begin
      r.sat   = 1'b1;
      r.value = bot[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- control FSM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (box_fire) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (fin_q && fin_axis_q == AXIS_W'(AXES - 1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        m_axis_tvalid_o = 1'b1;
        if (out_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- coefficient store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < COEF_COUNT; k++) coef_q[k] <= '0;
    end else if (load_fire && in_idx < COEF_IDX_W'(COEF_COUNT)) begin
      coef_q[in_idx] <= in_coef;
    end
  end

  always_ff @(posedge clk_i) begin
    if (box_fire) begin
      for (int j = 0; j < AXES; j++) begin
        lo_bnd_q[j] <= s_axis_tdata_i[BOX_LSB + j * COORD_WIDTH +: COORD_WIDTH];
        hi_bnd_q[j] <= s_axis_tdata_i[BOX_LSB + (AXES + j) * COORD_WIDTH +: COORD_WIDTH];
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  // per row: translation fetch, then (col, side) = (0,0) (0,1) (1,0) (1,1) (2,0) (2,1)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      axis_q  <= '0;
      col_q   <= COL_TRANS;
      side_q  <= 1'b0;
    end else if (box_fire) begin
      issue_q <= 1'b1;
      axis_q  <= '0;
      col_q   <= COL_TRANS;
      side_q  <= 1'b0;
    end else if (issue_q) begin
      if (col_q == COL_TRANS) begin
        col_q  <= '0;
        side_q <= 1'b0;
      end else if (!side_q) begin
        side_q <= 1'b1;
      end else begin
        side_q <= 1'b0;
        if (col_q == COL_LAST) begin
          col_q <= COL_TRANS;
          if (axis_q == AXIS_W'(AXES - 1)) begin
            issue_q <= 1'b0;
          end else begin
            axis_q <= axis_q + AXIS_W'(1);
          end
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------- shared multiplier
  assign coef_sel = coef_q[{axis_q, col_q}];
  assign bnd_sel  = side_q ? hi_bnd_q[col_q] : lo_bnd_q[col_q];

  always_ff @(posedge clk_i) begin
    prod_q <= prod_t'(coef_sel) * prod_t'(bnd_sel);
    if (issue_q && col_q == COL_TRANS) seed_q <= coef_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q.valid <= issue_q && (col_q != COL_TRANS);
      tag_q.side  <= side_q;
      tag_q.first <= (col_q == '0);
      tag_q.last  <= (col_q == COL_LAST) && side_q;
      tag_q.axis  <= axis_q;
    end
  end

  // ---------------------------------------------------------------- min/max accumulate
  assign seed_ext = acc_t'(seed_q) <<< FRAC_BITS;
  assign lo_base  = tag_q.first ? seed_ext : lo_acc_q;
  assign hi_base  = tag_q.first ? seed_ext : hi_acc_q;
  // prod_q is the max-bound product, p_q the min-bound one; swap when max < min
  assign mn       = (prod_q < p_q) ? prod_q : p_q;
  assign mx       = (prod_q < p_q) ? p_q : prod_q;

  always_ff @(posedge clk_i) begin
    if (tag_q.valid && !tag_q.side) p_q <= prod_q;
    if (tag_q.valid && tag_q.side) begin
      lo_acc_q <= lo_base + acc_t'(mn);
      hi_acc_q <= hi_base + acc_t'(mx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q      <= 1'b0;
      fin_axis_q <= '0;
    end else begin
      fin_q      <= tag_q.valid && tag_q.last;
      fin_axis_q <= tag_q.axis;
    end
  end

  // ---------------------------------------------------------------- round, clamp, hold
  assign fin_lo = finish(lo_acc_q);
  assign fin_hi = finish(hi_acc_q);

  always_ff @(posedge clk_i) begin
    if (fin_q) begin
      out_lo_q[fin_axis_q] <= fin_lo.value;
      out_hi_q[fin_axis_q] <= fin_hi.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (box_fire) begin
      sat_q <= 1'b0;
    end else if (fin_q) begin
      sat_q <= sat_q | fin_lo.sat | fin_hi.sat;
    end
  end

  assign m_axis_tdata_o = OUT_DATA_W'({out_hi_q[2], out_hi_q[1], out_hi_q[0],
                                       out_lo_q[2], out_lo_q[1], out_lo_q[0]});
  assign m_axis_tuser_o = sat_q;

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a result word is pending");

  a_box_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_fire |=> (state_q == ST_RUN) && issue_q)
    else $error("box word did not start the sequencer");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire |=> !m_axis_tvalid_o)
    else $error("load word produced a result word");

  a_fin_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> (state_q == ST_RUN))
    else $error("row finished outside a run");

  a_issue_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q |-> (state_q == ST_RUN))
    else $error("multiplier issuing outside a run");
`endif

endmodule
